/* design/assert_macros.svh */
// Assertion macros used by the checker file tpec_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge while reset is released.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/tpec_pkg.sv */
package tpec_pkg;

    localparam int CHANNELS_DEF    = 8;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int MAX_EVENTS      = 3;

    typedef enum logic [2:0] {
        KIND_PRESSED   = 3'd0,
        KIND_SHORT     = 3'd1,
        KIND_LONG      = 3'd2,
        KIND_VERY_LONG = 3'd3,
        KIND_MULTI     = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        REG_TOUCH_THRESHOLD = 3'd0,
        REG_DEBOUNCE_LIMIT  = 3'd1,
        REG_SHORT_PRESS_MS  = 3'd2,
        REG_LONG_PRESS_MS   = 3'd3,
        REG_VERY_LONG_MS    = 3'd4,
        REG_MULTI_PRESS_MS  = 3'd5
    } reg_idx_t;

    localparam logic [15:0] THRESHOLD_RST  = 16'd90;
    localparam logic [7:0]  DEBOUNCE_RST   = 8'd3;
    localparam logic [15:0] SHORT_RST      = 16'd500;
    localparam logic [15:0] LONG_RST       = 16'd1000;
    localparam logic [15:0] VERY_LONG_RST  = 16'd1500;
    localparam logic [15:0] MULTI_RST      = 16'd300;

    typedef struct packed {
        logic [15:0] touch_threshold;
        logic [7:0]  debounce_limit;
        logic [15:0] short_press_ms;
        logic [15:0] long_press_ms;
        logic [15:0] very_long_press_ms;
        logic [15:0] multi_press_ms;
    } cfg_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] value;
    } event_t;

    // All events caused by one sample; count is 1 to 3 for a queued bundle.
    typedef struct packed {
        logic [2:0]           channel;
        logic [1:0]           count;
        event_t [MAX_EVENTS-1:0] ev;
    } bundle_t;

endpackage

/* design/touch_press_event_classifier.sv */
// Touch press event classifier.
// Input stream: one beat per raw touch sample, s_tdata = channel, sample, now_ms.
// Output stream: one beat per event, m_tdata = event_channel, event_kind,
// event_value; m_tlast marks the final event caused by one sample. A sample
// may cause zero to three events; samples on channels at or above CHANNELS
// are taken and dropped without effect.
// Throughput: one sample per cycle on the input while s_tready is high. The
// per-channel state is read and written in the same cycle, so consecutive
// samples on one channel need no spacing. The output side sends one event
// beat per cycle while m_tready is high, so a sample with k events takes k beats.
// With the output side idle, the first event of a sample is written into the
// queue by the accepting edge and then loaded into the output register,
// where it becomes valid.
// The front and the output side are decoupled by a QUEUE_DEPTH-entry queue
// of event bundles; s_tready drops only while that queue is full, which
// happens when the receiver stalls m_tready long enough.
// Reset (aresetn low, synchronous) clears all channel state, empties the
// queue and loads the default configuration. cfg_we writes register cfg_index.
module touch_press_event_classifier #(
    parameter int CHANNELS    = tpec_pkg::CHANNELS_DEF,
    parameter int QUEUE_DEPTH = tpec_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // [2:0] channel, [18:3] sample, [50:19] now_ms
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [2:0] event_channel, [5:3] event_kind, [13:6] event_value
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);
    import tpec_pkg::*;

    cfg_t    cfg_reg, cfg_next;
    logic    q_push, q_full, q_pop, q_empty;
    bundle_t push_bundle, pop_bundle;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (reg_idx_t'(cfg_index))
                REG_TOUCH_THRESHOLD: cfg_next.touch_threshold    = cfg_wdata;
                REG_DEBOUNCE_LIMIT:  cfg_next.debounce_limit     = cfg_wdata[7:0];
                REG_SHORT_PRESS_MS:  cfg_next.short_press_ms     = cfg_wdata;
                REG_LONG_PRESS_MS:   cfg_next.long_press_ms      = cfg_wdata;
                REG_VERY_LONG_MS:    cfg_next.very_long_press_ms = cfg_wdata;
                REG_MULTI_PRESS_MS:  cfg_next.multi_press_ms     = cfg_wdata;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{touch_threshold:    THRESHOLD_RST,
                         debounce_limit:     DEBOUNCE_RST,
                         short_press_ms:     SHORT_RST,
                         long_press_ms:      LONG_RST,
                         very_long_press_ms: VERY_LONG_RST,
                         multi_press_ms:     MULTI_RST};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    tpec_front #(
        .CHANNELS(CHANNELS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_channel (s_tdata[2:0]),
        .in_sample  (s_tdata[18:3]),
        .in_now     (s_tdata[50:19]),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_bundle   (push_bundle)
    );

    tpec_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (push_bundle),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_bundle),
        .empty     (q_empty)
    );

    tpec_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_data   (pop_bundle),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

/* design/tpec_front.sv */
module tpec_front #(
    parameter int CHANNELS = tpec_pkg::CHANNELS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  tpec_pkg::cfg_t    cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2:0]        in_channel,
    input  logic [15:0]       in_sample,
    input  logic [31:0]       in_now,
    input  logic              q_full,
    output logic              q_push,
    output tpec_pkg::bundle_t q_bundle
);
    import tpec_pkg::*;

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic             pflag_reg  [CHANNELS];
    logic             lflag_reg  [CHANNELS];
    logic             vlflag_reg [CHANNELS];
    logic [7:0]       dcount_reg [CHANNELS];
    logic [7:0]       mcount_reg [CHANNELS];
    logic [31:0]      ptime_reg  [CHANNELS];

    logic [IDX_W+2:0] ch_ext;
    logic [IDX_W-1:0] idx;
    logic             in_range;
    logic             accept;

    logic [7:0]       limit;
    logic [8:0]       cnt_inc;
    logic             touched;
    logic [7:0]       cnt_next;
    logic             was;
    logic             now_p;
    logic [31:0]      elapsed;
    logic [7:0]       mc_inc;

    logic             pf_next;
    logic             lf_next;
    logic             vlf_next;
    logic [7:0]       mc_next;
    logic [31:0]      pt_next;

    event_t           cand   [MAX_EVENTS];
    logic             cand_v [MAX_EVENTS];
    event_t [MAX_EVENTS-1:0] slots;
    logic [1:0]       n_ev;

    assign ch_ext   = {{IDX_W{1'b0}}, in_channel};
    assign idx      = ch_ext[IDX_W-1:0];
    assign in_range = 32'(in_channel) < CHANNELS;
    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready && in_range;

    assign limit   = (cfg.debounce_limit == 8'd0) ? 8'd1 : cfg.debounce_limit;
    assign cnt_inc = {1'b0, dcount_reg[idx]} + 9'd1;
    assign touched = in_sample < cfg.touch_threshold;
    assign elapsed = in_now - ptime_reg[idx];
    assign mc_inc  = (mcount_reg[idx] == 8'hFF) ? 8'hFF : mcount_reg[idx] + 8'd1;

    always_comb begin
        if (touched) begin
            cnt_next = (cnt_inc < {1'b0, limit}) ? cnt_inc[7:0] : limit;
        end else begin
            cnt_next = (dcount_reg[idx] != 8'd0) ? dcount_reg[idx] - 8'd1 : 8'd0;
        end
        was   = pflag_reg[idx];
        now_p = was;
        if (was && cnt_next == 8'd0) begin
            now_p = 1'b0;
        end
        if (!was && cnt_next == limit) begin
            now_p = 1'b1;
        end
    end

    // Candidate events in output order, then packed down to the first slots.
    always_comb begin
        pf_next  = pflag_reg[idx];
        lf_next  = lflag_reg[idx];
        vlf_next = vlflag_reg[idx];
        mc_next  = mcount_reg[idx];
        pt_next  = ptime_reg[idx];
        for (int i = 0; i < MAX_EVENTS; i++) begin
            cand[i]   = '{kind: KIND_PRESSED, value: 8'd0};
            cand_v[i] = 1'b0;
        end
        if (now_p != was) begin
            pf_next  = now_p;
            lf_next  = 1'b0;
            vlf_next = 1'b0;
            if (now_p) begin
                pt_next   = in_now;
                mc_next   = mc_inc;
                cand[0]   = '{kind: KIND_PRESSED, value: 8'd1};
                cand_v[0] = 1'b1;
                cand[1]   = '{kind: KIND_MULTI, value: mc_inc};
                cand_v[1] = 1'b1;
            end else begin
                cand[0]   = '{kind: KIND_SHORT, value: 8'd0};
                cand_v[0] = elapsed < {16'd0, cfg.short_press_ms};
                cand[1]   = '{kind: KIND_PRESSED, value: 8'd0};
                cand_v[1] = 1'b1;
            end
        end else begin
            if (was && !lflag_reg[idx] && elapsed > {16'd0, cfg.long_press_ms}) begin
                lf_next   = 1'b1;
                cand[0]   = '{kind: KIND_LONG, value: 8'd0};
                cand_v[0] = 1'b1;
            end
            if (was && !vlflag_reg[idx] && elapsed > {16'd0, cfg.very_long_press_ms}) begin
                vlf_next  = 1'b1;
                cand[1]   = '{kind: KIND_VERY_LONG, value: 8'd0};
                cand_v[1] = 1'b1;
            end
            if (elapsed > {16'd0, cfg.multi_press_ms} && mcount_reg[idx] != 8'd0) begin
                mc_next   = 8'd0;
                cand[2]   = '{kind: KIND_MULTI, value: 8'd0};
                cand_v[2] = 1'b1;
            end
        end
    end

    always_comb begin
        slots = '0;
        n_ev  = 2'd0;
        for (int i = 0; i < MAX_EVENTS; i++) begin
            if (cand_v[i]) begin
                slots[n_ev] = cand[i];
                n_ev        = n_ev + 2'd1;
            end
        end
    end

    assign q_push   = accept && (n_ev != 2'd0);
    assign q_bundle = '{channel: in_channel, count: n_ev, ev: slots};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                pflag_reg[i]  <= 1'b0;
                lflag_reg[i]  <= 1'b0;
                vlflag_reg[i] <= 1'b0;
                dcount_reg[i] <= 8'd0;
                mcount_reg[i] <= 8'd0;
                ptime_reg[i]  <= 32'd0;
            end
        end else if (accept) begin
            pflag_reg[idx]  <= pf_next;
            lflag_reg[idx]  <= lf_next;
            vlflag_reg[idx] <= vlf_next;
            dcount_reg[idx] <= cnt_next;
            mcount_reg[idx] <= mc_next;
            ptime_reg[idx]  <= pt_next;
        end
    end

endmodule

/* design/tpec_queue.sv */
module tpec_queue #(
    parameter int DEPTH = tpec_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  tpec_pkg::bundle_t push_data,
    output logic              full,
    input  logic              pop,
    output tpec_pkg::bundle_t pop_data,
    output logic              empty
);
    import tpec_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bundle_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full     = count_reg == CNT_W'(DEPTH);
    assign empty    = count_reg == '0;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* design/tpec_back.sv */
module tpec_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_empty,
    input  tpec_pkg::bundle_t q_data,
    output logic              q_pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,
    output logic              m_tlast
);
    import tpec_pkg::*;

    logic        busy_reg, busy_next;
    bundle_t     cur_reg, cur_next;
    logic [1:0]  idx_reg, idx_next;
    logic        take;
    logic        at_last;
    event_t      ev;

    assign ev       = cur_reg.ev[idx_reg];
    assign at_last  = idx_reg == (cur_reg.count - 2'd1);
    assign take     = busy_reg && m_tready;
    assign m_tvalid = busy_reg;
    assign m_tlast  = at_last;
    assign m_tdata  = {2'b00, ev.value, ev.kind, cur_reg.channel};

    // A new bundle loads in the cycle the final beat of the previous one leaves.
    assign q_pop = (!busy_reg || (take && at_last)) && !q_empty;

    always_comb begin
        busy_next = busy_reg;
        cur_next  = cur_reg;
        idx_next  = idx_reg;
        if (q_pop) begin
            busy_next = 1'b1;
            cur_next  = q_data;
            idx_next  = 2'd0;
        end else if (take) begin
            if (at_last) begin
                busy_next = 1'b0;
            end else begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
    end

endmodule

/* design/tpec_checker.sv */
`include "assert_macros.svh"

module tpec_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);
    import tpec_pkg::*;

    logic [2:0] kind;
    logic [7:0] value;

    assign kind  = m_tdata[5:3];
    assign value = m_tdata[13:6];

    `ASSERT_CLK(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled beat changed")
    `ASSERT_ALWAYS(a_reset_quiet, aclk, !aresetn |=> !m_tvalid, "beat right after reset")
    `ASSERT_CLK(a_kind_range, aclk, aresetn, m_tvalid |-> kind <= KIND_MULTI, "event kind out of range")
    `ASSERT_CLK(a_short_then_release, aclk, aresetn, m_tvalid && kind == KIND_SHORT |-> !m_tlast, "short press not followed by release")
    `ASSERT_CLK(a_pressed_value, aclk, aresetn, m_tvalid && kind == KIND_PRESSED |-> value[7:1] == 7'd0, "pressed event value not 0 or 1")

endmodule

bind touch_press_event_classifier tpec_checker u_tpec_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

/* tb/sv/touch_press_event_classifier_test.sv */
module touch_press_event_classifier_test;

    import tpec_pkg::*;

    localparam int CHANNELS = CHANNELS_DEF;

    typedef struct {
        logic [2:0]  ch;
        logic [15:0] smp;
        logic [31:0] now_ms;
    } touch_sample_t;

    typedef struct {
        logic [2:0] ch;
        kind_t      kind;
        logic [7:0] value;
        logic       last;
    } touch_ev_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;

    touch_press_event_classifier i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Register copies used by the predictor and by the stimulus generator.
    logic [15:0] cfg_threshold = THRESHOLD_RST;
    logic [7:0]  cfg_debounce  = DEBOUNCE_RST;
    logic [15:0] cfg_short     = SHORT_RST;
    logic [15:0] cfg_long      = LONG_RST;
    logic [15:0] cfg_very_long = VERY_LONG_RST;
    logic [15:0] cfg_multi     = MULTI_RST;

    // Per-pad state of the predictor.
    logic        pad_down   [CHANNELS];
    logic [7:0]  pad_count  [CHANNELS];
    logic [7:0]  pad_multi  [CHANNELS];
    logic [31:0] pad_t0     [CHANNELS];
    logic        pad_long   [CHANNELS];
    logic        pad_vlong  [CHANNELS];

    touch_sample_t pending_samples[$];
    touch_ev_t     expected_events[$];
    touch_sample_t cur_beat;
    touch_ev_t     want;

    int unsigned clock_ms = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          samples_taken = 0;
    int          events_checked = 0;
    int          fail_count = 0;
    int          kind_seen[5] = '{0, 0, 0, 0, 0};

    initial begin
        for (int i = 0; i < CHANNELS; i++) begin
            pad_down[i]  = 1'b0;
            pad_count[i] = '0;
            pad_multi[i] = '0;
            pad_t0[i]    = '0;
            pad_long[i]  = 1'b0;
            pad_vlong[i] = 1'b0;
        end
    end

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("touch_press_event_classifier test failed");
        $finish;
    end

    // Works out the events that one accepted sample causes.
    function automatic void classify_sample(input touch_sample_t b);
        int unsigned lim;
        int unsigned cnt;
        logic        was_down;
        logic        is_down;
        logic [31:0] elapsed;
        touch_ev_t   evs[$];
        if (b.ch >= CHANNELS) return;
        lim = (cfg_debounce == 8'd0) ? 1 : cfg_debounce;
        cnt = pad_count[b.ch];
        if (b.smp < cfg_threshold) cnt = (cnt + 1 < lim) ? cnt + 1 : lim;
        else cnt = (cnt > 0) ? cnt - 1 : 0;
        pad_count[b.ch] = 8'(cnt);

        was_down = pad_down[b.ch];
        is_down = was_down;
        if (was_down && cnt == 0) is_down = 1'b0;
        if (!was_down && cnt == lim) is_down = 1'b1;
        elapsed = b.now_ms - pad_t0[b.ch];

        if (is_down != was_down) begin
            pad_down[b.ch]  = is_down;
            pad_long[b.ch]  = 1'b0;
            pad_vlong[b.ch] = 1'b0;
            if (is_down) begin
                pad_t0[b.ch] = b.now_ms;
                evs.push_back('{b.ch, KIND_PRESSED, 8'd1, 1'b0});
                if (pad_multi[b.ch] < 8'd255) pad_multi[b.ch]++;
                evs.push_back('{b.ch, KIND_MULTI, pad_multi[b.ch], 1'b0});
            end else begin
                if (elapsed < cfg_short) evs.push_back('{b.ch, KIND_SHORT, 8'd0, 1'b0});
                evs.push_back('{b.ch, KIND_PRESSED, 8'd0, 1'b0});
            end
        end else begin
            if (was_down) begin
                if (!pad_long[b.ch] && elapsed > cfg_long) begin
                    pad_long[b.ch] = 1'b1;
                    evs.push_back('{b.ch, KIND_LONG, 8'd0, 1'b0});
                end
                if (!pad_vlong[b.ch] && elapsed > cfg_very_long) begin
                    pad_vlong[b.ch] = 1'b1;
                    evs.push_back('{b.ch, KIND_VERY_LONG, 8'd0, 1'b0});
                end
            end
            if (elapsed > cfg_multi && pad_multi[b.ch] > 8'd0) begin
                pad_multi[b.ch] = 8'd0;
                evs.push_back('{b.ch, KIND_MULTI, 8'd0, 1'b0});
            end
        end

        if (evs.size() > 0) evs[evs.size() - 1].last = 1'b1;
        foreach (evs[i]) expected_events.push_back(evs[i]);
    endfunction

    // Sample driver: after each taken beat, the next is sent or idles at random.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                classify_sample(cur_beat);
                samples_taken++;
            end
            if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                cur_beat = pending_samples.pop_front();
                s_tdata  <= {5'b0, cur_beat.now_ms, cur_beat.smp, cur_beat.ch};
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Event monitor.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                events_checked++;
                if (m_tdata[5:3] < 3'd5) kind_seen[m_tdata[5:3]]++;
                if (expected_events.size() == 0) begin
                    $error("unexpected event beat: channel %0d kind %0d value %0d",
                           m_tdata[2:0], m_tdata[5:3], m_tdata[13:6]);
                    fail_count++;
                end else begin
                    want = expected_events.pop_front();
                    if (m_tdata[2:0] !== want.ch) begin
                        $error("event_channel: expected %0d, got %0d", want.ch, m_tdata[2:0]);
                        fail_count++;
                    end
                    if (m_tdata[5:3] !== want.kind) begin
                        $error("event_kind: expected %0d, got %0d", want.kind, m_tdata[5:3]);
                        fail_count++;
                    end
                    if (m_tdata[13:6] !== want.value) begin
                        $error("event_value: expected %0d, got %0d", want.value,
                               m_tdata[13:6]);
                        fail_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, m_tlast);
                        fail_count++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_TOUCH_THRESHOLD: cfg_threshold = val;
            REG_DEBOUNCE_LIMIT:  cfg_debounce  = val[7:0];
            REG_SHORT_PRESS_MS:  cfg_short     = val;
            REG_LONG_PRESS_MS:   cfg_long      = val;
            REG_VERY_LONG_MS:    cfg_very_long = val;
            REG_MULTI_PRESS_MS:  cfg_multi     = val;
            default: ;
        endcase
    endtask

    task automatic configure(input logic [15:0] thr, input logic [15:0] deb,
                             input logic [15:0] sh, input logic [15:0] lg,
                             input logic [15:0] vl, input logic [15:0] mp);
        write_reg(REG_TOUCH_THRESHOLD, thr);
        write_reg(REG_DEBOUNCE_LIMIT, deb);
        write_reg(REG_SHORT_PRESS_MS, sh);
        write_reg(REG_LONG_PRESS_MS, lg);
        write_reg(REG_VERY_LONG_MS, vl);
        write_reg(REG_MULTI_PRESS_MS, mp);
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    // Waits until every sample is taken and every event has arrived, then keeps
    // waiting before it returns, since the last samples may have caused nothing.
    task automatic drain;
        do @(negedge aclk);
        while (pending_samples.size() != 0 || s_tvalid || expected_events.size() != 0);
        repeat (10) @(negedge aclk);
    endtask

    task automatic add_sample(input logic [2:0] ch, input logic [15:0] smp,
                              input int unsigned dt);
        clock_ms = clock_ms + dt;
        pending_samples.push_back('{ch, smp, clock_ms});
    endtask

    task automatic add_at(input logic [2:0] ch, input logic [15:0] smp,
                          input logic [31:0] at_ms);
        pending_samples.push_back('{ch, smp, at_ms});
    endtask

    function automatic logic [15:0] touch_level();
        if (cfg_threshold == 16'd0) return 16'($urandom_range(65535));
        return 16'($urandom_range(cfg_threshold - 1, 0));
    endfunction

    function automatic logic [15:0] release_level();
        return 16'($urandom_range(65535, cfg_threshold));
    endfunction

    // Touch, hold, release and quiet samples on one pad, with bounces mixed in.
    task automatic press_sequence(input logic [2:0] ch);
        int unsigned lim;
        int unsigned n;
        int unsigned hold_ms;
        int unsigned n_hold;
        lim = (cfg_debounce == 8'd0) ? 1 : cfg_debounce;
        n = lim + $urandom_range(2);
        if ($urandom_range(9) < 2) n = $urandom_range(lim, 1);
        for (int i = 0; i < n; i++) add_sample(ch, touch_level(), $urandom_range(20, 1));
        case ($urandom_range(3))
            0: hold_ms = $urandom_range(cfg_short, 0);
            1: hold_ms = cfg_long + $urandom_range(60, 1);
            2: hold_ms = cfg_very_long + $urandom_range(60, 1);
            default: hold_ms = $urandom_range(70000);
        endcase
        n_hold = $urandom_range(3);
        for (int i = 0; i < n_hold; i++) begin
            add_sample(ch, ($urandom_range(99) < 85) ? touch_level() : release_level(),
                       hold_ms / n_hold);
        end
        n = lim + $urandom_range(2);
        for (int i = 0; i < n; i++) begin
            add_sample(ch, release_level(),
                       (i == 0 && n_hold == 0) ? hold_ms : $urandom_range(20, 1));
        end
        if ($urandom_range(1) == 1) begin
            add_sample(ch, release_level(),
                       ($urandom_range(1) == 1) ? cfg_multi + $urandom_range(40, 1)
                                                : $urandom_range(20));
        end
    endtask

    task automatic random_batch(input int unsigned count);
        int unsigned start;
        start = pending_samples.size();
        while (pending_samples.size() - start < count) begin
            if ($urandom_range(99) < 20) begin
                if ($urandom_range(1) == 1)
                    add_at(3'($urandom_range(7)), 16'($urandom), $urandom);
                else
                    add_sample(3'($urandom_range(7)), 16'($urandom), $urandom_range(50));
            end else begin
                press_sequence(3'($urandom_range(7)));
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Default settings, both sides always ready.
        // Pad 0: press at threshold floor, quick release, then multi-press timeout.
        add_at(3'd0, 16'd0, 32'd100);
        add_at(3'd0, 16'd0, 32'd101);
        add_at(3'd0, 16'd0, 32'd102);
        add_at(3'd0, 16'hFFFF, 32'd200);
        add_at(3'd0, 16'hFFFF, 32'd201);
        add_at(3'd0, 16'hFFFF, 32'd202);
        add_at(3'd0, 16'hFFFF, 32'd700);
        // Pad 7: just below and at the threshold, long then very long hold.
        add_at(3'd7, 16'd89, 32'd1000);
        add_at(3'd7, 16'd89, 32'd1001);
        add_at(3'd7, 16'd89, 32'd1002);
        add_at(3'd7, 16'd90, 32'd1500);
        add_at(3'd7, 16'd0, 32'd2100);
        add_at(3'd7, 16'd0, 32'd2600);
        add_at(3'd7, 16'hFFFF, 32'd2700);
        add_at(3'd7, 16'hFFFF, 32'd2701);
        add_at(3'd7, 16'hFFFF, 32'd2702);
        // Pad 3: the millisecond counter wraps between press and release.
        add_at(3'd3, 16'd1, 32'hFFFF_FFF0);
        add_at(3'd3, 16'd1, 32'hFFFF_FFF1);
        add_at(3'd3, 16'd1, 32'hFFFF_FFF2);
        add_at(3'd3, 16'd65535, 32'd5);
        add_at(3'd3, 16'd65535, 32'd6);
        add_at(3'd3, 16'd65535, 32'd7);
        // Pad 4: stray readings with alternating bit patterns.
        add_at(3'd4, 16'h5555, 32'hAAAA_AAAA);
        add_at(3'd4, 16'h0000, 32'h5555_5555);
        add_at(3'd4, 16'hAAAA, 32'hFFFF_FFFF);
        clock_ms = 3000;
        random_batch(30);
        drain();

        // Threshold at its top, a zero debounce limit and zero windows.
        configure(16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_idle_pct = 47;
        random_batch(40);
        drain();

        // Largest debounce limit: pads 2 and 3 climb well past a later, lower limit.
        configure(16'h8000, 16'd255, 16'd200, 16'd400, 16'd800, 16'd100);
        send_idle_pct = 0;
        recv_stall_pct = 47;
        for (int i = 0; i < 20; i++) add_sample(3'd2, touch_level(), 5);
        for (int i = 0; i < 20; i++) add_sample(3'd3, touch_level(), 5);
        drain();
        configure(16'h8000, 16'd2, 16'd200, 16'd400, 16'd800, 16'd100);
        add_sample(3'd2, release_level(), 5);
        add_sample(3'd2, touch_level(), 5);
        add_sample(3'd3, touch_level(), 5);
        random_batch(20);
        drain();

        // Random windows near the counter wrap, light idling on both sides.
        configure(16'($urandom_range(40000, 100)), 16'd4, 16'($urandom_range(2000)),
                  16'($urandom_range(3000)), 16'($urandom_range(6000)),
                  16'($urandom_range(1000)));
        send_idle_pct = 6;
        recv_stall_pct = 6;
        clock_ms = 32'hFFFF_FF00;
        random_batch(40);
        drain();

        // Rapid taps on one pad build up a multi-press count.
        configure(16'd90, 16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < 10; i++) begin
            add_sample(3'd5, 16'd0, 1);
            add_sample(3'd5, 16'hFFFF, 1);
        end
        random_batch(10);
        drain();

        $display("Took %0d touch samples and checked %0d event beats over six register sets.",
                 samples_taken, events_checked);
        $display("Events seen: pressed %0d, short %0d, long %0d, very long %0d, multi %0d.",
                 kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4]);
        if (fail_count == 0) begin
            $display("touch_press_event_classifier test passed");
        end else begin
            $display("touch_press_event_classifier test failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+design
design/tpec_pkg.sv
design/tpec_front.sv
design/tpec_queue.sv
design/tpec_back.sv
design/touch_press_event_classifier.sv
design/tpec_checker.sv
tb/sv/touch_press_event_classifier_test.sv
